// ===== sv/r9e5_pkg.sv =====
package r9e5_pkg;

  localparam int unsigned FloatW    = 32;
  localparam int unsigned MantW     = 9;
  localparam int unsigned ExpW      = 5;
  localparam int unsigned RoundW    = 11;
  localparam logic [31:0] ClampBits = 32'h477F_8000;
  localparam logic [7:0]  ExpFloor  = 8'd111;
  localparam logic [RoundW-1:0] MantLimit = 11'd512;

  typedef logic [30:0] comp_t;

  // clamp to [0, 65408]; nan goes high, negatives go to zero
  function automatic comp_t clamp_comp(input logic [31:0] b);
    comp_t r;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
      r = ClampBits[30:0];
    end else if (b[31]) begin
      r = '0;
    end else if (b > ClampBits) begin
      r = ClampBits[30:0];
    end else begin
      r = b[30:0];
    end
    return r;
  endfunction

  // biased exponent before the round-up correction
  function automatic logic [ExpW-1:0] pre_exp(input comp_t b);
    logic [7:0] e;
    logic [7:0] d;
    e = b[30:23];
    d = e - ExpFloor;
    return (e < ExpFloor) ? '0 : d[ExpW-1:0];
  endfunction

  // round half up of b * 2^(24 - ex); denormals always fall to zero
  function automatic logic [RoundW-1:0] round_scaled(input comp_t b, input logic [5:0] ex);
    logic [8:0]  sh;
    logic [24:0] sum;
    logic [24:0] q;
    logic [RoundW-1:0] r;
    sh  = {3'd0, ex} + 9'd126 - {1'b0, b[30:23]};
    sum = {2'b01, b[22:0]} + (25'd1 << (sh[4:0] - 5'd1));
    q   = sum >> sh[4:0];
    if (b[30:23] == 8'd0 || sh > 9'd25 || sh == 9'd0 || sh[8]) begin
      r = '0;
    end else begin
      r = q[RoundW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/rgb9e5_shared_exponent_encoder_unit.sv =====
// an accepted transaction passes the stage registers of this unit, then the output register in r9e5_quant
// throughput: one transaction per cycle; a held output stalls the whole pipe
// stages: clamp, component max, pre-exponent and rounded max, final rounding
// reset: synchronous active-high rst clears all stage valid bits
// data registers are not reset
module rgb9e5_shared_exponent_encoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          src_valid,
  output logic                          src_stall,
  input  logic [31:0]                   red_bits,
  input  logic [31:0]                   green_bits,
  input  logic [31:0]                   blue_bits,
  output logic                          dst_valid,
  input  logic                          dst_stall,
  output logic [r9e5_pkg::MantW-1:0]    red_mantissa,
  output logic [r9e5_pkg::MantW-1:0]    green_mantissa,
  output logic [r9e5_pkg::MantW-1:0]    blue_mantissa,
  output logic [r9e5_pkg::ExpW-1:0]     shared_exponent
);
  import r9e5_pkg::*;

  logic en;
  logic v1, v2, v3;
  comp_t r1, g1, b1;
  comp_t r2, g2, b2, max2;
  comp_t r3, g3, b3;
  logic [ExpW-1:0]   expp3;
  logic [RoundW-1:0] smax3;
  logic [5:0]        exps;
  comp_t max_next;
  logic [ExpW-1:0]   expp_next;

  assign en        = !(dst_valid && dst_stall);
  assign src_stall = !en;

  always_comb begin
    max_next = r1;
    if (g1 > max_next) max_next = g1;
    if (b1 > max_next) max_next = b1;
    expp_next = pre_exp(max2);
    exps = {1'b0, expp3} + ((smax3 < MantLimit) ? 6'd0 : 6'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      dst_valid <= 1'b0;
    end else if (en) begin
      v1 <= src_valid;
      v2 <= v1;
      v3 <= v2;
      dst_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= clamp_comp(red_bits);
      g1 <= clamp_comp(green_bits);
      b1 <= clamp_comp(blue_bits);
      r2 <= r1;
      g2 <= g1;
      b2 <= b1;
      max2 <= max_next;
      r3 <= r2;
      g3 <= g2;
      b3 <= b2;
      expp3 <= expp_next;
      smax3 <= round_scaled(max2, {1'b0, expp_next});
    end
  end

  r9e5_quant u_quant (
    .clk  (clk),
    .en   (en),
    .exps (exps),
    .cr   (r3),
    .cg   (g3),
    .cb   (b3),
    .mr   (red_mantissa),
    .mg   (green_mantissa),
    .mb   (blue_mantissa),
    .ex   (shared_exponent)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> !v1 && !v2 && !v3 && !dst_valid)
    else $error("valid bits not cleared by reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst) en && v3 |=> dst_valid)
    else $error("stage three transaction lost");

  a_normalized: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> shared_exponent == '0 || red_mantissa[MantW-1] ||
      green_mantissa[MantW-1] || blue_mantissa[MantW-1])
    else $error("largest mantissa not normalized");

endmodule

// ===== sv/r9e5_quant.sv =====
module r9e5_quant (
  input  logic                          clk,
  input  logic                          en,
  input  logic [5:0]                    exps,
  input  r9e5_pkg::comp_t               cr,
  input  r9e5_pkg::comp_t               cg,
  input  r9e5_pkg::comp_t               cb,
  output logic [r9e5_pkg::MantW-1:0]    mr,
  output logic [r9e5_pkg::MantW-1:0]    mg,
  output logic [r9e5_pkg::MantW-1:0]    mb,
  output logic [r9e5_pkg::ExpW-1:0]     ex
);
  import r9e5_pkg::*;

  logic [RoundW-1:0] rr;
  logic [RoundW-1:0] rg;
  logic [RoundW-1:0] rb;

  always_comb begin
    rr = round_scaled(cr, exps);
    rg = round_scaled(cg, exps);
    rb = round_scaled(cb, exps);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mr <= rr[MantW-1:0];
      mg <= rg[MantW-1:0];
      mb <= rb[MantW-1:0];
      ex <= exps[ExpW-1:0];
    end
  end

endmodule
